// ===== rtl/core/hrhp_pkg.sv =====
// Package for the HTTP response header parser: result record, result kinds,
// character codes and the two header prefixes. No dependencies.
package hrhp_pkg;

    localparam int unsigned TAG_IDX_W = 6;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned STATUS_W  = 16;

    // Result kinds, carried on the master tuser.
    localparam logic [1:0] KIND_TAG  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [4:0] TAG_PFX_LEN = 5'd7;
    localparam logic [4:0] LEN_PFX_LEN = 5'd16;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           out_byte;
        logic [TAG_IDX_W-1:0] tag_index;
        logic [STATUS_W-1:0]  status_code;
        logic [LEN_W-1:0]     content_length;
        logic [TAG_IDX_W-1:0] tag_length;
        logic                 accepted;
        logic                 body_last;
    } hrhp_result_t;

    // Characters of the entity tag prefix: ETag, colon, space, double quote.
    function automatic logic [7:0] tag_pfx_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h45; // E
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h67; // g
            3'd4:    c = 8'h3A; // :
            3'd5:    c = 8'h20; // space
            3'd6:    c = 8'h22; // double quote
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the "Content-Length: " prefix.
    function automatic logic [7:0] len_pfx_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hrhp_parse.sv =====
// Per-byte parse step of the HTTP response header parser: parse state
// registers and the next-state and result logic. Depends on hrhp_pkg.
module hrhp_parse #(
    parameter int unsigned TAG_MAX_CHARS = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            data_byte,
    input  logic                  start_req,
    output logic                  res_valid,
    output hrhp_pkg::hrhp_result_t res
);
    import hrhp_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [1:0] LK_UNDECIDED = 2'd0;
    localparam logic [1:0] LK_TAG       = 2'd1;
    localparam logic [1:0] LK_LENGTH    = 2'd2;
    localparam logic [1:0] LK_OTHER     = 2'd3;

    localparam logic [TAG_IDX_W-1:0] TAG_CAP = TAG_IDX_W'(TAG_MAX_CHARS);

    typedef struct packed {
        logic [1:0]           phase;
        logic [1:0]           crlf_run;
        logic [4:0]           line_position;
        logic [1:0]           line_kind;
        logic [15:0]          held_chars;
        logic [1:0]           held_count;
        logic [TAG_IDX_W-1:0] tag_count;
        logic [LEN_W-1:0]     length_value;
        logic [1:0]           status_phase;
        logic [STATUS_W-1:0]  status_value;
        logic [LEN_W-1:0]     body_count;
        logic                 body_accepted;
    } hrhp_state_t;

    localparam hrhp_state_t STATE_RESET = '{
        phase:         PH_HEADER,
        line_kind:     LK_UNDECIDED,
        default:       '0
    };

    hrhp_state_t          state_reg;
    hrhp_state_t          state_next;
    hrhp_state_t          cur;
    logic                 prev_cr;
    logic                 is_digit;
    logic                 is_space;
    logic [3:0]           digit;
    logic [19:0]          status_prod;
    logic [35:0]          len_prod;
    logic                 tag_clear;
    logic [TAG_IDX_W-1:0] tag_base;
    logic [15:0]          held_shift;
    logic [LEN_W-1:0]     body_inc;
    logic                 acc;

    assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_space    = (data_byte == CH_SP) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    assign digit       = data_byte[3:0];

    always_comb
    begin
        cur        = start_req ? STATE_RESET : state_reg;
        state_next = cur;
        res        = '0;
        res_valid  = 1'b0;
        prev_cr    = cur.crlf_run[0];
        // Times ten as two shifts and an add.
        status_prod = ({4'b0, cur.status_value} << 3) + ({4'b0, cur.status_value} << 1)
                    + {16'b0, digit};
        len_prod    = ({4'b0, cur.length_value} << 3) + ({4'b0, cur.length_value} << 1)
                    + {32'b0, digit};
        tag_clear   = ((cur.held_count == 2'd0) && (data_byte != CH_CR))
                    || ((cur.held_count == 2'd1) && prev_cr);
        tag_base    = tag_clear ? '0 : cur.tag_count;
        held_shift  = cur.held_chars >> 8;
        body_inc    = (cur.body_count == '1) ? cur.body_count : cur.body_count + 1'b1;
        acc         = (cur.status_value == 16'd200) || (cur.status_value == 16'd206);

        unique case (cur.phase)
            PH_HEADER:
            begin
                // Status code: digits right after the first space.
                if (cur.status_phase == 2'd0)
                begin
                    if (data_byte == CH_SP)
                        state_next.status_phase = 2'd1;
                end
                else if (cur.status_phase == 2'd1)
                begin
                    if (is_digit)
                        state_next.status_value = (status_prod > 20'hFFFF) ? 16'hFFFF
                                                                           : status_prod[15:0];
                    else
                        state_next.status_phase = 2'd2;
                end

                if ((data_byte == CH_LF) && prev_cr)
                begin
                    state_next.line_position = '0;
                    state_next.line_kind     = LK_UNDECIDED;
                    state_next.held_chars    = '0;
                    state_next.held_count    = '0;
                    if (cur.crlf_run == 2'd3)
                    begin
                        // Blank line: header is complete.
                        state_next.crlf_run      = 2'd0;
                        state_next.body_accepted = acc;
                        state_next.body_count    = '0;
                        state_next.phase         = acc ? PH_BODY : PH_DONE;
                        res_valid                = 1'b1;
                        res.kind                 = KIND_DONE;
                        res.status_code          = state_next.status_value;
                        res.content_length       = cur.length_value;
                        res.tag_length           = cur.tag_count;
                        res.accepted             = acc;
                    end
                    else
                    begin
                        state_next.crlf_run = 2'd2;
                    end
                end
                else
                begin
                    if (data_byte == CH_CR)
                        state_next.crlf_run = (cur.crlf_run == 2'd2) ? 2'd3 : 2'd1;
                    else
                        state_next.crlf_run = 2'd0;

                    unique case (cur.line_kind)
                        LK_UNDECIDED:
                        begin
                            if (data_byte == tag_pfx_char(3'd0))
                            begin
                                state_next.line_kind     = LK_TAG;
                                state_next.line_position = 5'd1;
                            end
                            else if (data_byte == len_pfx_char(4'd0))
                            begin
                                state_next.line_kind     = LK_LENGTH;
                                state_next.line_position = 5'd1;
                            end
                            else
                            begin
                                state_next.line_kind = LK_OTHER;
                            end
                        end
                        LK_TAG:
                        begin
                            if (cur.line_position < TAG_PFX_LEN)
                            begin
                                if (data_byte == tag_pfx_char(cur.line_position[2:0]))
                                    state_next.line_position = cur.line_position + 5'd1;
                                else
                                    state_next.line_kind = LK_OTHER;
                            end
                            else if (((data_byte == CH_CR) && (cur.held_count < 2'd2))
                                     || (cur.held_count == 2'd0))
                            begin
                                // Hold the byte back: it may be the closing character.
                                state_next.tag_count  = tag_base;
                                state_next.held_chars = cur.held_chars
                                    | (cur.held_count[0] ? {data_byte, 8'h00} : {8'h00, data_byte});
                                state_next.held_count = cur.held_count + 2'd1;
                            end
                            else
                            begin
                                // Release the oldest held byte and hold this one.
                                state_next.held_chars = held_shift
                                    | ((cur.held_count == 2'd2) ? {data_byte, 8'h00}
                                                                : {8'h00, data_byte});
                                if (tag_base < TAG_CAP)
                                begin
                                    res_valid            = 1'b1;
                                    res.kind             = KIND_TAG;
                                    res.out_byte         = cur.held_chars[7:0];
                                    res.tag_index        = tag_base;
                                    state_next.tag_count = tag_base + 1'b1;
                                end
                                else
                                begin
                                    state_next.tag_count = tag_base;
                                end
                            end
                        end
                        LK_LENGTH:
                        begin
                            if (cur.line_position < LEN_PFX_LEN)
                            begin
                                if (data_byte == len_pfx_char(cur.line_position[3:0]))
                                    state_next.line_position = cur.line_position + 5'd1;
                                else
                                    state_next.line_kind = LK_OTHER;
                            end
                            else if (cur.line_position == LEN_PFX_LEN)
                            begin
                                // A lone CR right after the prefix keeps the old value.
                                if (prev_cr || (data_byte != CH_CR))
                                    state_next.length_value = '0;
                                if (is_digit)
                                begin
                                    state_next.length_value  = {28'b0, digit};
                                    state_next.line_position = LEN_PFX_LEN + 5'd1;
                                end
                                else if (!is_space)
                                begin
                                    state_next.line_kind = LK_OTHER;
                                end
                            end
                            else if (is_digit)
                            begin
                                state_next.length_value = (len_prod > 36'hFFFF_FFFF) ? '1
                                                                                     : len_prod[31:0];
                            end
                            else
                            begin
                                state_next.line_kind = LK_OTHER;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_BODY:
            begin
                state_next.body_count = body_inc;
                res_valid             = 1'b1;
                res.kind              = KIND_BODY;
                res.out_byte          = data_byte;
                res.body_last         = (body_inc == cur.length_value);
                if (body_inc == cur.length_value)
                    state_next.phase = PH_DONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (step_en)
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/http_response_header_parser_top.sv =====
// Top level of the HTTP response header parser: stream ports, input word
// register and result register. Depends on hrhp_pkg and hrhp_parse.

// The parser takes one response byte per word and sustains one word per
// clock cycle while the input side is not stalled. A word is captured in an
// input register, the parse step for that byte works on the registered byte,
// and its result (if it has one) is captured in the output register, from
// which it is presented. The input side stalls only while a finished result
// waits in the output register and the sink holds tready low; bytes that give
// no result still move through the pipeline at one per cycle when no such
// stall holds. Setting the tuser bit on a word clears all parse state before
// that byte is parsed, so it is the first byte of a new response.
// Result words carry an entity tag character, a header summary, or a
// forwarded body byte, told apart by tuser; tlast marks the body byte whose
// count reaches the parsed Content-Length.
module http_response_header_parser_top #(
    parameter int unsigned TAG_MAX_CHARS = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
    input  logic        s_axis_tuser,  // start_req[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // out_byte[7:0], tag_index[13:8],
                                       // status_code[29:14], content_length[61:30],
                                       // tag_length[67:62], accepted[68], zeros[71:69]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast   // body_last
);
    import hrhp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;
    logic         out_valid_reg;
    hrhp_result_t out_res_reg;
    logic         advance;
    logic         step_valid;
    hrhp_result_t step_res;

    // The whole pipeline moves whenever the output register is free or is
    // being emptied this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    hrhp_parse #(
        .TAG_MAX_CHARS(TAG_MAX_CHARS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance && in_valid_reg),
        .data_byte (in_byte_reg),
        .start_req (in_start_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= s_axis_tvalid;
            out_valid_reg <= in_valid_reg && step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
            out_res_reg  <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.body_last;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.accepted,
                            out_res_reg.tag_length,
                            out_res_reg.content_length,
                            out_res_reg.status_code,
                            out_res_reg.tag_index,
                            out_res_reg.out_byte};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for http_response_header_parser_top: byte words go in,
// tag, summary and body words are checked against a parse model kept here.
// Depends on hrhp_pkg and the parser RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int unsigned TAG_LIMIT    = 63;
    localparam int unsigned ITEM_TARGET  = 600;
    localparam int unsigned IDLE_PCT     = 13;
    localparam int unsigned LIMIT_CYCLES = 200000;
    // The result of a byte passes the input and output registers after its word is taken.
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam string ETAG_PREFIX = "ETag: \"";
    localparam string CLEN_PREFIX = "Content-Length: ";

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DONE} parse_phase_e;
    typedef enum logic [1:0] {LINE_UNDECIDED, LINE_TAG, LINE_LENGTH, LINE_OTHER} line_kind_e;
    typedef enum logic [1:0] {STAT_SEEK, STAT_DIGITS, STAT_DONE} status_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stim_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    stim_word_t   response_bytes[$];
    stim_word_t   next_word;
    hrhp_result_t pending_results[$];

    int unsigned cycle = 0;
    int unsigned mismatches = 0;
    int unsigned stim_count = 0;
    logic        calm;

    // Stimulus builder state: the start flag rides on the next byte added, and
    // body_hint is the body size the current response is expected to carry.
    logic        start_next = 1'b1;
    logic        counted = 1'b1;
    int unsigned body_hint = 0;

    // Shadow copy of the parser state.
    parse_phase_e  p_phase;
    logic [1:0]    p_crlf;
    logic [4:0]    p_pos;
    line_kind_e    p_line;
    logic [15:0]   p_held;
    logic [1:0]    p_held_n;
    int unsigned   p_tags;
    logic [31:0]   p_len;
    status_phase_e p_stat_ph;
    logic [15:0]   p_status;
    logic [31:0]   p_body_n;

    http_response_header_parser_top #(
        .TAG_MAX_CHARS(TAG_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Both sides run without any idling for a stretch in the middle of the run.
    assign calm = (cycle >= 300) && (cycle < 520);

    // Cycle count and the hard limit on the run.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == LIMIT_CYCLES)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    task automatic clear_line();
        p_pos    = '0;
        p_line   = LINE_UNDECIDED;
        p_held   = '0;
        p_held_n = '0;
    endtask

    task automatic clear_parse();
        p_phase   = PH_HEADER;
        p_crlf    = '0;
        clear_line();
        p_tags    = 0;
        p_len     = '0;
        p_stat_ph = STAT_SEEK;
        p_status  = '0;
        p_body_n  = '0;
    endtask

    // Advances the model by one accepted byte and queues the word it causes.
    task automatic parse_response_byte(input logic [7:0] b, input logic start);
        hrhp_result_t     r;
        bit               have;
        bit               prev_cr;
        bit               acc;
        logic [7:0]       front;
        int unsigned      sv;
        longint unsigned  lv;
        r    = '0;
        have = 1'b0;
        if (start)
            clear_parse();
        case (p_phase)
            PH_BODY:
            begin
                if (p_body_n != 32'hFFFF_FFFF)
                    p_body_n = p_body_n + 32'd1;
                r.kind      = KIND_BODY;
                r.out_byte  = b;
                r.body_last = (p_body_n == p_len);
                if (r.body_last)
                    p_phase = PH_DONE;
                have = 1'b1;
            end
            PH_HEADER:
            begin
                prev_cr = p_crlf[0];
                // The status code is the digit run right after the first space.
                if (p_stat_ph == STAT_SEEK)
                begin
                    if (b == CH_SP)
                        p_stat_ph = STAT_DIGITS;
                end
                else if (p_stat_ph == STAT_DIGITS)
                begin
                    if (is_digit(b))
                    begin
                        sv = 32'(p_status) * 10 + 32'(b - CH_ZERO);
                        p_status = (sv > 32'hFFFF) ? 16'hFFFF : sv[15:0];
                    end
                    else
                        p_stat_ph = STAT_DONE;
                end

                if (b == CH_LF && prev_cr)
                begin
                    clear_line();
                    if (p_crlf == 2'd3)
                    begin
                        // Blank line: the header is over.
                        acc              = (p_status == 16'd200) || (p_status == 16'd206);
                        p_crlf           = '0;
                        r.kind           = KIND_DONE;
                        r.status_code    = p_status;
                        r.content_length = p_len;
                        r.tag_length     = p_tags[5:0];
                        r.accepted       = acc;
                        p_body_n         = '0;
                        p_phase          = acc ? PH_BODY : PH_DONE;
                        have             = 1'b1;
                    end
                    else
                        p_crlf = 2'd2;
                end
                else
                begin
                    p_crlf = (b == CH_CR) ? ((p_crlf == 2'd2) ? 2'd3 : 2'd1) : 2'd0;
                    case (p_line)
                        LINE_UNDECIDED:
                        begin
                            if (b == ETAG_PREFIX[0])
                            begin
                                p_line = LINE_TAG;
                                p_pos  = 5'd1;
                            end
                            else if (b == CLEN_PREFIX[0])
                            begin
                                p_line = LINE_LENGTH;
                                p_pos  = 5'd1;
                            end
                            else
                                p_line = LINE_OTHER;
                        end
                        LINE_TAG:
                        begin
                            if (p_pos < 5'(ETAG_PREFIX.len()))
                            begin
                                if (b == ETAG_PREFIX[p_pos])
                                    p_pos = p_pos + 5'd1;
                                else
                                    p_line = LINE_OTHER;
                            end
                            else
                            begin
                                // One character (two while a CR is pending) is held
                                // back so that the closing quote is never emitted.
                                if ((p_held_n == 0 && b != CH_CR) || (p_held_n == 1 && prev_cr))
                                    p_tags = 0;
                                if ((b == CH_CR && p_held_n < 2) || p_held_n == 0)
                                begin
                                    p_held   = p_held | ({8'h00, b} << (8 * p_held_n));
                                    p_held_n = p_held_n + 2'd1;
                                end
                                else
                                begin
                                    front    = p_held[7:0];
                                    p_held   = p_held >> 8;
                                    p_held_n = p_held_n - 2'd1;
                                    p_held   = p_held | ({8'h00, b} << (8 * p_held_n));
                                    p_held_n = p_held_n + 2'd1;
                                    if (p_tags < TAG_LIMIT)
                                    begin
                                        r.kind      = KIND_TAG;
                                        r.out_byte  = front;
                                        r.tag_index = p_tags[5:0];
                                        p_tags      = p_tags + 1;
                                        have        = 1'b1;
                                    end
                                end
                            end
                        end
                        LINE_LENGTH:
                        begin
                            if (p_pos < 5'(CLEN_PREFIX.len()))
                            begin
                                if (b == CLEN_PREFIX[p_pos])
                                    p_pos = p_pos + 5'd1;
                                else
                                    p_line = LINE_OTHER;
                            end
                            else if (p_pos == 5'(CLEN_PREFIX.len()))
                            begin
                                // Still skipping whitespace before the first digit.
                                if (prev_cr || b != CH_CR)
                                    p_len = '0;
                                if (is_digit(b))
                                begin
                                    p_len = 32'(b - CH_ZERO);
                                    p_pos = p_pos + 5'd1;
                                end
                                else if (!is_space(b))
                                    p_line = LINE_OTHER;
                            end
                            else if (is_digit(b))
                            begin
                                lv = 64'(p_len) * 10 + 64'(b - CH_ZERO);
                                p_len = (lv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lv[31:0];
                            end
                            else
                                p_line = LINE_OTHER;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (have)
            pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b);
        response_bytes.push_back('{data: b, start: start_next});
        start_next = 1'b0;
        if (counted)
            stim_count++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic add_length_line();
        int unsigned n;
        add_text(CLEN_PREFIX);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                n = $urandom_range(0, 9);
                add_text($sformatf("%0d", n));
                body_hint = n;
            end
            4:
            begin
                n = $urandom_range(10, 20);
                add_text($sformatf("%0d", n));
                body_hint = n;
            end
            5:
            begin
                // Leading whitespace, a lone CR among it.
                add_byte(CH_SP);
                add_byte(CH_TAB);
                add_byte(CH_CR);
                add_text("3");
                body_hint = 3;
            end
            6:
            begin
                // At and beyond the 32-bit limit: the value saturates.
                if ($urandom_range(1))
                    add_text("4294967295");
                else
                    add_text("99999999999");
                body_hint = 4;
            end
            7:
            begin
                // No digits, or a sign: the value becomes zero.
                add_text($urandom_range(1) ? "x7" : "-5");
                body_hint = 0;
            end
            8: ; // nothing after the prefix keeps the previous value
            default:
            begin
                add_text("12ab");
                body_hint = 12;
            end
        endcase
        add_crlf();
    endtask

    task automatic add_tag_line();
        int unsigned n;
        add_text(ETAG_PREFIX);
        // Now and then a tag near the cap, sometimes longer than it.
        n = ($urandom_range(11) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                add_byte(CH_CR);
            else
                add_byte(printable());
        end
        if ($urandom_range(7) != 0)
            add_text("\"");
        add_crlf();
    endtask

    task automatic add_other_line();
        int unsigned n;
        case ($urandom_range(0, 7))
            0: add_text("Content-Lengt: 5");
            1: add_text("Content-Length:5");
            2: add_text("ETag: x");
            3: add_text("ETag \"q\"");
            default:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(3) == 0)
                        add_byte(8'($urandom_range(0, 255)));
                    else
                        add_byte(printable());
                end
            end
        endcase
        add_crlf();
    endtask

    // A response: status line, a few header lines, the blank line and a body.
    task automatic add_response();
        int unsigned n;
        bit          no_space;
        string       code;
        start_next = 1'b1;
        counted    = 1'b1;
        body_hint  = 0;
        case ($urandom_range(0, 3))
            0: add_text("HTTP/1.1");
            1: add_text("H");
            2: ;
            default: add_text("HTTP/1.0");
        endcase
        no_space = ($urandom_range(0, 11) == 0);
        case ($urandom_range(0, 10))
            0, 1, 2, 3: code = "200";
            4, 5:       code = "206";
            6:          code = "404";
            7:          code = $sformatf("%0d", $urandom_range(0, 999));
            8:          code = "99999";
            9:          code = "";
            default:    code = "0206";
        endcase
        if (!no_space)
            add_byte(CH_SP);
        add_text(code);
        if ($urandom_range(1))
            add_text(" OK");
        add_crlf();

        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 2))
                0:       add_length_line();
                1:       add_tag_line();
                default: add_other_line();
            endcase
        end

        // Some responses are cut off inside the header.
        if ($urandom_range(9) == 0)
            return;
        add_crlf();

        n = (body_hint == 0) ? $urandom_range(0, 6) : body_hint;
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
        // Extra bytes are ignored once the body has ended, else forwarded as body.
        counted = 1'b0;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
        counted = 1'b1;
    endtask

    // Raw bytes with an occasional start flag.
    task automatic add_noise();
        int unsigned n;
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++)
        begin
            start_next = ($urandom_range(7) == 0);
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: feeds the queued byte words, idling now and then.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (response_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_word = response_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_word.data;
                s_axis_tuser  <= next_word.start;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Every byte word taken by the block advances the model.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            parse_response_byte(s_axis_tdata, s_axis_tuser);
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and the check of each result word.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string why, input hrhp_result_t e,
                                   input hrhp_result_t a);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d", why, cycle);
            $display("  expected kind=%0d byte=%02h idx=%0d status=%0d len=%0d",
                     e.kind, e.out_byte, e.tag_index, e.status_code, e.content_length);
            $display("           tlen=%0d acc=%0d last=%0d",
                     e.tag_length, e.accepted, e.body_last);
            $display("  actual   kind=%0d byte=%02h idx=%0d status=%0d len=%0d",
                     a.kind, a.out_byte, a.tag_index, a.status_code, a.content_length);
            $display("           tlen=%0d acc=%0d last=%0d",
                     a.tag_length, a.accepted, a.body_last);
        end
    endtask

    task automatic check_result_word();
        hrhp_result_t got;
        hrhp_result_t want;
        got.kind           = m_axis_tuser;
        got.out_byte       = m_axis_tdata[7:0];
        got.tag_index      = m_axis_tdata[13:8];
        got.status_code    = m_axis_tdata[29:14];
        got.content_length = m_axis_tdata[61:30];
        got.tag_length     = m_axis_tdata[67:62];
        got.accepted       = m_axis_tdata[68];
        got.body_last      = m_axis_tlast;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result word", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte
            || got.tag_index !== want.tag_index || got.status_code !== want.status_code
            || got.content_length !== want.content_length
            || got.tag_length !== want.tag_length || got.accepted !== want.accepted
            || got.body_last !== want.body_last)
            report_mismatch("result word mismatch", want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result_word();
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, reset, run, drain and report.
    // ------------------------------------------------------------------
    initial
    begin
        clear_parse();

        // Directed start: a 206 with no length, whose body bytes (all ones,
        // all zeros) are forwarded and never marked last; then a rejected
        // 404 after which a stray byte is ignored.
        start_next = 1'b1;
        add_byte(8'h00);
        add_text(" 206");
        add_crlf();
        add_crlf();
        add_byte(8'hFF);
        add_byte(8'h00);
        start_next = 1'b1;
        add_text(" 404");
        add_crlf();
        add_crlf();
        counted = 1'b0;
        add_text("Z");
        counted = 1'b1;

        // Mostly well-formed responses with random content, some noise.
        while (stim_count < ITEM_TARGET)
        begin
            if ($urandom_range(9) == 0)
                add_noise();
            else
                add_response();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (response_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
